// ----- rtl/lssp_pkg.sv -----
// lssp_pkg: shared types and constants of the line steering and speed PID block.
// No dependencies. Imported by every module under rtl.
package lssp_pkg;

  localparam int GainW   = 16;
  localparam int CfgGW   = 3 * GainW;
  localparam int SpeedW  = 10;
  localparam int DbandW  = 7;
  localparam int ErrW    = 8;
  localparam int DiffW   = ErrW + 1;
  localparam int ProdW   = GainW + DiffW;
  localparam int CfgDW   = 64;
  localparam int CfgAW   = 6;

  localparam int IntLimit = 100;
  localparam int OutLimit = 1000;

  // floor(m / 35) == (m * ceil(2^30 / 35)) >> 30 for m < 2^24
  localparam int          MagW       = 24;
  localparam int          RecipW     = 25;
  localparam int          RecipShift = 30;
  localparam logic [RecipW-1:0] RecipDiv35 = 25'd30678338;

  typedef enum logic [2:0] {
    REG_STEER_GAINS = 3'd0,
    REG_SPEED_GAINS = 3'd1,
    REG_DIFF_GAINS  = 3'd2,
    REG_SPEED_MAX   = 3'd3,
    REG_SPEED_MIN   = 3'd4,
    REG_DIFF_LIMIT  = 3'd5,
    REG_DEAD_BAND   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CfgGW-1:0]  steer_gains;
    logic [CfgGW-1:0]  speed_gains;
    logic [CfgGW-1:0]  diff_gains;
    logic [SpeedW-1:0] speed_max;
    logic [SpeedW-1:0] speed_min;
    logic [SpeedW-1:0] diff_limit;
    logic [DbandW-1:0] dead_band;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [DiffW-1:0] dif;
    logic signed [ErrW-1:0]  integ;
  } pid_terms_t;

  typedef struct packed {
    pid_terms_t steer;
    pid_terms_t speed;
  } err_terms_t;

endpackage

// ----- rtl/lssp_cfg_regs.sv -----
// lssp_cfg_regs: APB register file for gains, speed limits and dead band.
// Depends on lssp_pkg (cfg_t, reg_idx_t).
module lssp_cfg_regs import lssp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [CfgAW-1:0] paddr,
  input  logic [CfgDW-1:0] pwdata,
  output logic [CfgDW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CfgAW-1:3]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_STEER_GAINS: cfg_nxt.steer_gains = pwdata[CfgGW-1:0];
        REG_SPEED_GAINS: cfg_nxt.speed_gains = pwdata[CfgGW-1:0];
        REG_DIFF_GAINS:  cfg_nxt.diff_gains  = pwdata[CfgGW-1:0];
        REG_SPEED_MAX:   cfg_nxt.speed_max   = pwdata[SpeedW-1:0];
        REG_SPEED_MIN:   cfg_nxt.speed_min   = pwdata[SpeedW-1:0];
        REG_DIFF_LIMIT:  cfg_nxt.diff_limit  = pwdata[SpeedW-1:0];
        REG_DEAD_BAND:   cfg_nxt.dead_band   = pwdata[DbandW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STEER_GAINS: prdata = CfgDW'(cfg_r.steer_gains);
      REG_SPEED_GAINS: prdata = CfgDW'(cfg_r.speed_gains);
      REG_DIFF_GAINS:  prdata = CfgDW'(cfg_r.diff_gains);
      REG_SPEED_MAX:   prdata = CfgDW'(cfg_r.speed_max);
      REG_SPEED_MIN:   prdata = CfgDW'(cfg_r.speed_min);
      REG_DIFF_LIMIT:  prdata = CfgDW'(cfg_r.diff_limit);
      REG_DEAD_BAND:   prdata = CfgDW'(cfg_r.dead_band);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/lssp_err_stage.sv -----
// lssp_err_stage: input register stage; error, difference and integral of both loops.
// Holds the loop history. Depends on lssp_pkg.
module lssp_err_stage import lssp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            in_valid,
  input  logic [ErrW-1:0] in_data,
  output logic            in_ready,
  input  logic            down_ready,
  output logic            terms_valid,
  output err_terms_t      terms
);

  logic signed [ErrW-1:0] steer_last_r, steer_last_nxt;
  logic signed [ErrW-1:0] steer_int_r, steer_int_nxt;
  logic signed [ErrW-1:0] speed_last_r, speed_last_nxt;
  logic signed [ErrW-1:0] speed_int_r, speed_int_nxt;
  logic                   vld_r, vld_nxt;
  err_terms_t             terms_r, terms_nxt;

  logic                   accept;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] spd_err;
  logic [ErrW-1:0]        mag;

  function automatic logic signed [ErrW-1:0] clamp_int(logic signed [ErrW-1:0] acc,
                                                       logic signed [ErrW-1:0] x);
    logic signed [DiffW-1:0] s;
    s = DiffW'(acc) + DiffW'(x);
    if (s > IntLimit) return ErrW'(IntLimit);
    else if (s < -IntLimit) return ErrW'(-IntLimit);
    else return s[ErrW-1:0];
  endfunction

  assign in_ready    = !vld_r || down_ready;
  assign accept      = in_valid && in_ready;
  assign terms_valid = vld_r;
  assign terms       = terms_r;

  assign err     = $signed(in_data);
  assign mag     = err[ErrW-1] ? (~in_data + 1'b1) : in_data;
  // speed loop only reacts outside the dead band
  assign spd_err = (mag > {1'b0, cfg.dead_band}) ? err : '0;

  always_comb begin
    terms_nxt.steer.err   = err;
    terms_nxt.steer.dif   = DiffW'(err) - DiffW'(steer_last_r);
    terms_nxt.steer.integ = clamp_int(steer_int_r, err);
    terms_nxt.speed.err   = spd_err;
    terms_nxt.speed.dif   = DiffW'(spd_err) - DiffW'(speed_last_r);
    terms_nxt.speed.integ = clamp_int(speed_int_r, spd_err);
  end

  always_comb begin
    steer_last_nxt = steer_last_r;
    steer_int_nxt  = steer_int_r;
    speed_last_nxt = speed_last_r;
    speed_int_nxt  = speed_int_r;
    if (accept) begin
      steer_last_nxt = terms_nxt.steer.err;
      steer_int_nxt  = terms_nxt.steer.integ;
      speed_last_nxt = terms_nxt.speed.err;
      speed_int_nxt  = terms_nxt.speed.integ;
    end
    vld_nxt = in_ready ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_last_r <= '0;
      steer_int_r  <= '0;
      speed_last_r <= '0;
      speed_int_r  <= '0;
      vld_r        <= 1'b0;
    end else begin
      steer_last_r <= steer_last_nxt;
      steer_int_r  <= steer_int_nxt;
      speed_last_r <= speed_last_nxt;
      speed_int_r  <= speed_int_nxt;
      vld_r        <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      terms_r <= terms_nxt;
    end
  end

endmodule

// ----- rtl/lssp_pid_pipe.sv -----
// lssp_pid_pipe: products, sums, divide by 35, speed shaping and output register.
// Four stages with per-stage valid so bubbles close up. Depends on lssp_pkg.
module lssp_pid_pipe import lssp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  err_terms_t  terms,
  output logic        in_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  localparam int SumW = ProdW + 2;
  localparam int QuoW = MagW + RecipW - RecipShift;
  localparam logic signed [SumW-1:0] Sat16Hi = 27'sd32767;
  localparam logic signed [SumW-1:0] Sat16Lo = -27'sd32768;

  // stage valids and readies
  logic p_vld_r, s_vld_r, q_vld_r, o_vld_r;
  logic p_vld_nxt, s_vld_nxt, q_vld_nxt, o_vld_nxt;
  logic p_rdy, s_rdy, q_rdy, o_rdy;

  // product stage: [loop][slot], loop 0 steer, 1 speed, 2 differential
  logic signed [ProdW-1:0] prod_r [3][3];
  logic signed [ProdW-1:0] prod_nxt [3][3];

  // sum stage
  logic              steer_neg_r, steer_neg_nxt;
  logic [MagW-1:0]   steer_mag_r, steer_mag_nxt;
  logic signed [15:0] spd_sat_r, spd_sat_nxt;
  logic signed [15:0] dif_sat_r, dif_sat_nxt;

  // quotient stage
  logic              servo_neg_r, servo_neg_nxt;
  logic [SpeedW-1:0] servo_mag_r, servo_mag_nxt;
  logic [SpeedW-1:0] base_r, base_nxt;
  logic signed [SpeedW:0] diffc_r, diffc_nxt;

  // output stage
  logic signed [SpeedW:0] servo_r, servo_nxt;
  logic [SpeedW-1:0] left_r, left_nxt;
  logic [SpeedW-1:0] right_r, right_nxt;

  function automatic logic signed [ProdW-1:0] mul_gain(logic [CfgGW-1:0] g, int slot,
                                                       logic signed [DiffW-1:0] x);
    logic signed [GainW-1:0] k;
    k = $signed(g[GainW*slot +: GainW]);
    return ProdW'(k) * ProdW'(x);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [SumW-1:0] v);
    if (v > Sat16Hi) return 16'sh7fff;
    else if (v < Sat16Lo) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic [SpeedW-1:0] clamp_wheel(logic signed [SpeedW+1:0] v);
    if (v < 0) return '0;
    else if (v > OutLimit) return SpeedW'(OutLimit);
    else return v[SpeedW-1:0];
  endfunction

  assign o_rdy    = !o_vld_r || out_tready;
  assign q_rdy    = !q_vld_r || o_rdy;
  assign s_rdy    = !s_vld_r || q_rdy;
  assign p_rdy    = !p_vld_r || s_rdy;
  assign in_ready = p_rdy;

  assign p_vld_nxt = p_rdy ? in_valid : p_vld_r;
  assign s_vld_nxt = s_rdy ? p_vld_r  : s_vld_r;
  assign q_vld_nxt = q_rdy ? s_vld_r  : q_vld_r;
  assign o_vld_nxt = o_rdy ? q_vld_r  : o_vld_r;

  // products
  always_comb begin
    prod_nxt[0][0] = mul_gain(cfg.steer_gains, 0, DiffW'(terms.steer.err));
    prod_nxt[0][1] = mul_gain(cfg.steer_gains, 1, terms.steer.dif);
    prod_nxt[0][2] = mul_gain(cfg.steer_gains, 2, DiffW'(terms.steer.integ));
    prod_nxt[1][0] = mul_gain(cfg.speed_gains, 0, DiffW'(terms.speed.err));
    prod_nxt[1][1] = mul_gain(cfg.speed_gains, 1, terms.speed.dif);
    prod_nxt[1][2] = mul_gain(cfg.speed_gains, 2, DiffW'(terms.speed.integ));
    prod_nxt[2][0] = mul_gain(cfg.diff_gains, 0, DiffW'(terms.speed.err));
    prod_nxt[2][1] = mul_gain(cfg.diff_gains, 1, terms.speed.dif);
    prod_nxt[2][2] = mul_gain(cfg.diff_gains, 2, DiffW'(terms.speed.integ));
  end

  // sums
  always_comb begin
    logic signed [SumW-1:0] st_sum;
    logic signed [SumW-1:0] st_abs;
    st_sum = SumW'(prod_r[0][0]) + SumW'(prod_r[0][1]) + SumW'(prod_r[0][2]);
    st_abs = (st_sum < 0) ? -st_sum : st_sum;
    steer_neg_nxt = st_sum < 0;
    steer_mag_nxt = st_abs[MagW-1:0];
    spd_sat_nxt = sat16(SumW'(prod_r[1][0]) + SumW'(prod_r[1][1]) + SumW'(prod_r[1][2]));
    dif_sat_nxt = sat16(SumW'(prod_r[2][0]) + SumW'(prod_r[2][1]) + SumW'(prod_r[2][2]));
  end

  // divide by 35 on the magnitude (truncation toward zero), base speed, diff clamp
  always_comb begin
    logic [MagW+RecipW-1:0] qprod;
    logic [QuoW-1:0]        quo;
    logic signed [16:0]     spd_x;
    logic signed [16:0]     spd_abs;
    logic signed [17:0]     base_w;
    logic signed [16:0]     dif_x;
    logic signed [16:0]     lim_p;
    qprod = steer_mag_r * RecipDiv35;
    quo   = qprod[MagW+RecipW-1:RecipShift];
    servo_mag_nxt = (quo > OutLimit) ? SpeedW'(OutLimit) : quo[SpeedW-1:0];
    servo_neg_nxt = steer_neg_r;

    spd_x   = 17'(spd_sat_r);
    spd_abs = (spd_x < 0) ? -spd_x : spd_x;
    base_w  = $signed({8'd0, cfg.speed_max}) - 18'(spd_abs);
    if (base_w < $signed({8'd0, cfg.speed_min})) base_nxt = cfg.speed_min;
    else base_nxt = base_w[SpeedW-1:0];

    dif_x = 17'(dif_sat_r);
    lim_p = $signed({7'd0, cfg.diff_limit});
    if (dif_x > lim_p) diffc_nxt = lim_p[SpeedW:0];
    else if (dif_x < -lim_p) diffc_nxt = (SpeedW+1)'(-lim_p);
    else diffc_nxt = dif_x[SpeedW:0];
  end

  // final sign and wheel clamps
  always_comb begin
    logic signed [SpeedW:0]   smag;
    logic signed [SpeedW+1:0] lw;
    logic signed [SpeedW+1:0] rw;
    smag      = $signed({1'b0, servo_mag_r});
    servo_nxt = servo_neg_r ? -smag : smag;
    lw        = $signed({2'd0, base_r}) - (SpeedW+2)'(diffc_r);
    rw        = $signed({2'd0, base_r}) + (SpeedW+2)'(diffc_r);
    left_nxt  = clamp_wheel(lw);
    right_nxt = clamp_wheel(rw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      q_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
      s_vld_r <= s_vld_nxt;
      q_vld_r <= q_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy) begin
      prod_r <= prod_nxt;
    end
    if (s_rdy) begin
      steer_neg_r <= steer_neg_nxt;
      steer_mag_r <= steer_mag_nxt;
      spd_sat_r   <= spd_sat_nxt;
      dif_sat_r   <= dif_sat_nxt;
    end
    if (q_rdy) begin
      servo_neg_r <= servo_neg_nxt;
      servo_mag_r <= servo_mag_nxt;
      base_r      <= base_nxt;
      diffc_r     <= diffc_nxt;
    end
    if (o_rdy) begin
      servo_r <= servo_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {1'b0, right_r, left_r, servo_r};

endmodule

// ----- rtl/line_steer_speed_pid_top.sv -----
// line_steer_speed_pid_top: steering servo and wheel speed PID for a line follower.
// Instantiates lssp_cfg_regs, lssp_err_stage and lssp_pid_pipe; uses lssp_pkg.
//
//  channel | kind          | payload
//  --------+---------------+----------------------------------------------------
//  in_     | stream slave  | tdata[7:0] line_position (signed)
//  out_    | stream master | tdata[10:0] servo, [20:11] left, [30:21] right
//  cfg_    | APB slave     | 64-bit registers at 8*index, indexes 0..6
//
// One transaction per cycle sustained while out_tready stays high. The input register
// loads on the accepting edge, then the product, sum, divide by 35 and output registers
// load in turn; out_tvalid comes from the output register.
// The divide is a reciprocal multiply of 24 by 25 bits; it sets the longest stage.
// Reset (synchronous, rst_n low) clears loop history, config registers and valids.
// Each stage holds while the one after it is full and stalled.
module line_steer_speed_pid_top import lssp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] line_position
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // [10:0] servo_position, [20:11] left_speed,
                                       // [30:21] right_speed, [31] zero
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [CfgAW-1:0] cfg_paddr,
  input  logic [CfgDW-1:0] cfg_pwdata,
  output logic [CfgDW-1:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_t       cfg;
  err_terms_t terms;
  logic       terms_valid;
  logic       pipe_ready;

  lssp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lssp_err_stage u_err (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_tvalid),
    .in_data     (in_tdata),
    .in_ready    (in_tready),
    .down_ready  (pipe_ready),
    .terms_valid (terms_valid),
    .terms       (terms)
  );

  lssp_pid_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (terms_valid),
    .terms      (terms),
    .in_ready   (pipe_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
